### rtl/stia_pkg.sv
// ============================================================================
// stia_pkg: shared types and codes of the slot table ID allocator
// Request codes, status codes, configuration register indexes, field widths.
// ============================================================================
`default_nettype none

package stia_pkg;

    // Fixed field widths of the channels and the configuration port.
    localparam int REQ_TYPE_W = 3;
    localparam int SLOT_ID_W  = 10;
    localparam int FOUND_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int LIMIT_W    = 11;
    localparam int FSIZE_W    = 7;
    localparam int START_W    = 11;

    // Request codes.
    localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER    = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_REGISTER_AT = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_ID   = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_REMOVE_HDL  = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR       = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_GET         = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SLOTS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [FSIZE_W-1:0] FSIZE_RESET = 7'd64;
    localparam logic [START_W-1:0] START_RESET = 11'd100;

endpackage

`default_nettype wire

### rtl/stia_if.sv
// ============================================================================
// stia_if: request and response channels of the slot table ID allocator
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
`default_nettype none

interface stia_req_if
    import stia_pkg::*;
#(
    parameter int HANDLE_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic [REQ_TYPE_W-1:0]   req_type;
    logic [HANDLE_WIDTH-1:0] handle;
    logic [SLOT_ID_W-1:0]    slot_id;

    modport source (output valid, output req_type, output handle, output slot_id,
                    input ready);
    modport sink   (input valid, input req_type, input handle, input slot_id,
                    output ready);
endinterface

interface stia_rsp_if
    import stia_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [SLOT_ID_W-1:0] given_id;
    logic [FOUND_W-1:0]   found_handle;
    logic                 ok;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output given_id, output found_handle, output ok,
                    output status, input ready);
    modport sink   (input valid, input given_id, input found_handle, input ok,
                    input status, output ready);
endinterface

`default_nettype wire

### rtl/slot_table_id_allocator_unit.sv
// ============================================================================
// slot_table_id_allocator_unit: free-list ID allocator over a slot table
// Hands out IDs for handles from a free-ID stack, refilled by hole scans
// and by growth of the in-use region; supports removal, clear and lookup.
// ============================================================================
// Usage: one request word enters on req and yields exactly one response word
// on rsp. Configuration is written on cfg_we/cfg_index/cfg_data while the
// block is idle. Each write to a defined index re-initializes the table.
// Each request runs through the sequencer around the slot memory and the
// free-stack memory, both of which have a registered read port:
//   register pops a free ID from the stack; with an empty stack it first
//   scans the in-use slots for holes and, if none is found, grows the in-use
//   region and pushes the new slots;
//   register at ID grows the region until the ID is covered, then searches
//   the stack for it; an out-of-range ID goes straight to the response;
//   remove by ID, remove by handle (a search over the slots), get, and clear
//   (a pass over the whole slot memory).
// After reset and after every write to a defined configuration index a
// clearing pass zeroes the slot memory; req.ready stays low then.
// A finished response sits in an output register; the next request is taken
// while that word waits. If the receiver stalls, a second finished response
// holds the sequencer until the output register frees up.
// ============================================================================
`default_nettype none

module slot_table_id_allocator_unit
    import stia_pkg::*;
#(
    parameter int TABLE_DEPTH  = 1024,
    parameter int FREE_DEPTH   = 64,
    parameter int GROW_STEP    = 100,
    parameter int HANDLE_WIDTH = 32
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    stia_req_if.sink                   req,
    stia_rsp_if.source                 rsp
);

    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int SW  = LW + 1;
    localparam int SAW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int FW  = $clog2(FREE_DEPTH + 1);
    localparam int KW  = ((FW > FSIZE_W) ? FW : FSIZE_W) + 1;
    localparam int XW  = (AW > SLOT_ID_W) ? AW : SLOT_ID_W;
    localparam int OW  = (HANDLE_WIDTH > FOUND_W) ? HANDLE_WIDTH : FOUND_W;
    localparam int HW  = HANDLE_WIDTH;

    typedef enum logic [4:0] {
        S_INIT, S_CLEAR, S_IDLE,
        S_SCAN_RD, S_SCAN_CHK, S_AFTER_SCAN, S_GROW, S_POP_DEC, S_POP_RD, S_POP_WR,
        S_RAI_GROW, S_RAI_RD, S_RAI_CHK,
        S_RMI_RD, S_RMI_CHK, S_RMH_RD, S_RMH_CHK, S_REMOVE,
        S_GET_RD, S_GET_CHK, S_DONE
    } state_t;

    state_t                state_reg;
    logic [LIMIT_W-1:0]    id_limit_reg;
    logic [FSIZE_W-1:0]    free_size_reg;
    logic [START_W-1:0]    start_reg;
    logic [CW-1:0]         siu_reg;
    logic [FW-1:0]         fc_reg;
    logic [CW-1:0]         idx_reg;
    logic [FW-1:0]         sidx_reg;
    logic                  clr_req_reg;
    logic [HW-1:0]         h_reg;
    logic [SLOT_ID_W-1:0]  sid_reg;
    logic [SLOT_ID_W-1:0]  res_given_reg;
    logic [FOUND_W-1:0]    res_found_reg;
    logic                  res_ok_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic                  out_valid_reg;
    logic [SLOT_ID_W-1:0]  out_given_reg;
    logic [FOUND_W-1:0]    out_found_reg;
    logic                  out_ok_reg;
    logic [STATUS_W-1:0]   out_status_reg;

    // Memories and their ports.
    logic [HW-1:0]  slot_mem [TABLE_DEPTH];
    logic [AW-1:0]  stk_mem  [FREE_DEPTH];
    logic [HW-1:0]  slot_rdata;
    logic [AW-1:0]  stk_rdata;
    logic           slot_we;
    logic [AW-1:0]  slot_waddr;
    logic [HW-1:0]  slot_wdata;
    logic [AW-1:0]  slot_raddr;
    logic           stk_we;
    logic [SAW-1:0] stk_waddr;
    logic [AW-1:0]  stk_wdata;
    logic [SAW-1:0] stk_raddr;

    // Derived sizes.
    logic [CW-1:0]  lim_w;
    logic [FW-1:0]  cap_w;
    logic [CW-1:0]  siu_init_w;
    logic [CW-1:0]  grown_w;
    logic [LW-1:0]  st_w;
    logic [SW-1:0]  gsum_w;
    logic [XW-1:0]  rsid_x;
    logic [XW-1:0]  pop_id_x;
    logic [XW-1:0]  stk_x;
    logic [OW-1:0]  found_x;
    logic           push_ok_w;
    logic           cfg_hit;

    // Clamp the configuration registers into their usable ranges.
    always_comb
    begin
        if (id_limit_reg == '0)
            lim_w = CW'(1);
        else if (LW'(id_limit_reg) > LW'(TABLE_DEPTH))
            lim_w = CW'(TABLE_DEPTH);
        else
            lim_w = CW'(id_limit_reg);

        if (free_size_reg == '0)
            cap_w = FW'(1);
        else if (KW'(free_size_reg) > KW'(FREE_DEPTH))
            cap_w = FW'(FREE_DEPTH);
        else
            cap_w = FW'(free_size_reg);

        st_w = LW'(start_reg);
        if (st_w == '0)
            st_w = LW'(1);
        if (st_w > LW'(lim_w))
            st_w = LW'(lim_w);
        siu_init_w = CW'(st_w);

        gsum_w  = SW'(siu_reg) + SW'(GROW_STEP);
        grown_w = (gsum_w > SW'(lim_w)) ? lim_w : CW'(gsum_w);
    end

    assign rsid_x    = XW'(sid_reg);
    assign pop_id_x  = XW'(stk_rdata);
    assign stk_x     = XW'(stk_rdata);
    assign found_x   = OW'(slot_rdata);
    assign push_ok_w = (KW'(fc_reg) + KW'(1)) < KW'(cap_w);

    // A write to one of the defined registers re-initializes the table.
    assign cfg_hit = cfg_we && (cfg_index == CFG_ID_LIMIT || cfg_index == CFG_FREE_SIZE ||
                                cfg_index == CFG_START_SLOTS);

    // Memory port selection by sequencer state.
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = idx_reg[AW-1:0];
        slot_wdata = '0;
        slot_raddr = idx_reg[AW-1:0];
        stk_we     = 1'b0;
        stk_waddr  = fc_reg[SAW-1:0];
        stk_wdata  = idx_reg[AW-1:0];
        stk_raddr  = sidx_reg[SAW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we = 1'b1;
            end
            S_SCAN_CHK:
            begin
                stk_we = (slot_rdata == '0);
            end
            S_GROW:
            begin
                stk_we = (idx_reg < siu_reg) && (fc_reg < cap_w);
            end
            S_POP_RD:
            begin
                stk_raddr = SAW'(fc_reg - FW'(1));
            end
            S_POP_WR:
            begin
                slot_we    = 1'b1;
                slot_waddr = stk_rdata;
                slot_wdata = h_reg;
            end
            S_RAI_GROW:
            begin
                slot_we    = (LW'(sid_reg) < LW'(siu_reg));
                slot_waddr = rsid_x[AW-1:0];
                slot_wdata = h_reg;
            end
            S_RMI_RD, S_GET_RD:
            begin
                slot_raddr = rsid_x[AW-1:0];
            end
            S_REMOVE:
            begin
                slot_we = 1'b1;
                stk_we  = push_ok_w;
            end
            default:
            begin
            end
        endcase
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rdata <= slot_mem[slot_raddr];
    end

    // Free-ID stack memory.
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        stk_rdata <= stk_mem[stk_raddr];
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.given_id     = out_given_reg;
    assign rsp.found_handle = out_found_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.status       = out_status_reg;

    // Sequencer, counters and response registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            id_limit_reg  <= LIMIT_RESET;
            free_size_reg <= FSIZE_RESET;
            start_reg     <= START_RESET;
            siu_reg       <= '0;
            fc_reg        <= '0;
            idx_reg       <= '0;
            sidx_reg      <= '0;
            clr_req_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Hand the output word over unless a new one is loaded now.
            if (out_valid_reg && rsp.ready && (state_reg != S_DONE || cfg_hit))
                out_valid_reg <= 1'b0;

            // Configuration writes re-initialize the table.
            if (cfg_hit)
            begin
                unique case (cfg_index)
                    CFG_ID_LIMIT:
                    begin
                        id_limit_reg <= cfg_data[LIMIT_W-1:0];
                    end
                    CFG_FREE_SIZE:
                    begin
                        free_size_reg <= cfg_data[FSIZE_W-1:0];
                    end
                    CFG_START_SLOTS:
                    begin
                        start_reg <= cfg_data[START_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
                state_reg <= S_INIT;
            end
            else
            begin
                unique case (state_reg)
                    S_INIT:
                    begin
                        siu_reg     <= siu_init_w;
                        fc_reg      <= '0;
                        idx_reg     <= '0;
                        clr_req_reg <= 1'b0;
                        state_reg   <= S_CLEAR;
                    end
                    S_CLEAR:
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        if (idx_reg == CW'(TABLE_DEPTH - 1))
                        begin
                            fc_reg    <= '0;
                            state_reg <= clr_req_reg ? S_DONE : S_IDLE;
                        end
                    end
                    S_IDLE:
                    begin
                        if (req.valid)
                        begin
                            h_reg          <= req.handle;
                            sid_reg        <= req.slot_id;
                            res_given_reg  <= '0;
                            res_found_reg  <= '0;
                            res_ok_reg     <= 1'b0;
                            res_status_reg <= ST_OK;
                            priority case (req.req_type)
                                REQ_REGISTER:
                                begin
                                    idx_reg   <= CW'(1);
                                    state_reg <= (fc_reg == '0) ? S_SCAN_RD : S_POP_DEC;
                                end
                                REQ_REGISTER_AT:
                                begin
                                    if (LW'(req.slot_id) >= LW'(lim_w))
                                    begin
                                        res_status_reg <= ST_RANGE;
                                        state_reg      <= S_DONE;
                                    end
                                    else
                                        state_reg <= S_RAI_GROW;
                                end
                                REQ_REMOVE_ID:
                                begin
                                    if (req.slot_id == '0 ||
                                        LW'(req.slot_id) >= LW'(siu_reg))
                                    begin
                                        res_status_reg <= ST_RANGE;
                                        state_reg      <= S_DONE;
                                    end
                                    else
                                        state_reg <= S_RMI_RD;
                                end
                                REQ_REMOVE_HDL:
                                begin
                                    res_status_reg <= ST_NOT_FOUND;
                                    idx_reg        <= CW'(1);
                                    state_reg      <= (req.handle == '0) ? S_DONE : S_RMH_RD;
                                end
                                REQ_CLEAR:
                                begin
                                    res_ok_reg  <= 1'b1;
                                    idx_reg     <= '0;
                                    fc_reg      <= '0;
                                    clr_req_reg <= 1'b1;
                                    state_reg   <= S_CLEAR;
                                end
                                REQ_GET:
                                begin
                                    res_ok_reg <= 1'b1;
                                    state_reg  <= (LW'(req.slot_id) < LW'(siu_reg)) ?
                                                  S_GET_RD : S_DONE;
                                end
                                default:
                                begin
                                    state_reg <= S_DONE;
                                end
                            endcase
                        end
                    end
                    // Hole scan over the in-use slots from ID 1.
                    S_SCAN_RD:
                    begin
                        state_reg <= ((idx_reg < siu_reg) && (fc_reg < cap_w)) ?
                                     S_SCAN_CHK : S_AFTER_SCAN;
                    end
                    S_SCAN_CHK:
                    begin
                        if (slot_rdata == '0)
                            fc_reg <= fc_reg + FW'(1);
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                    S_AFTER_SCAN:
                    begin
                        if (fc_reg == '0 && siu_reg < lim_w)
                        begin
                            idx_reg   <= siu_reg;
                            siu_reg   <= grown_w;
                            state_reg <= S_GROW;
                        end
                        else
                            state_reg <= S_POP_DEC;
                    end
                    // Push the newly grown slots.
                    S_GROW:
                    begin
                        if ((idx_reg < siu_reg) && (fc_reg < cap_w))
                        begin
                            fc_reg  <= fc_reg + FW'(1);
                            idx_reg <= idx_reg + CW'(1);
                        end
                        else
                            state_reg <= S_POP_DEC;
                    end
                    S_POP_DEC:
                    begin
                        if (fc_reg != '0)
                            state_reg <= S_POP_RD;
                        else
                        begin
                            res_status_reg <= ST_FULL;
                            state_reg      <= S_DONE;
                        end
                    end
                    S_POP_RD:
                    begin
                        fc_reg    <= fc_reg - FW'(1);
                        state_reg <= S_POP_WR;
                    end
                    S_POP_WR:
                    begin
                        res_given_reg <= pop_id_x[SLOT_ID_W-1:0];
                        res_ok_reg    <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    // Register at ID: grow until the ID is covered, then search.
                    S_RAI_GROW:
                    begin
                        if (LW'(sid_reg) >= LW'(siu_reg))
                            siu_reg <= grown_w;
                        else
                        begin
                            sidx_reg  <= '0;
                            state_reg <= S_RAI_RD;
                        end
                    end
                    S_RAI_RD:
                    begin
                        if (sidx_reg < fc_reg)
                            state_reg <= S_RAI_CHK;
                        else
                        begin
                            res_given_reg <= sid_reg;
                            res_ok_reg    <= 1'b1;
                            state_reg     <= S_DONE;
                        end
                    end
                    S_RAI_CHK:
                    begin
                        if (stk_x == rsid_x)
                        begin
                            fc_reg        <= sidx_reg;
                            res_given_reg <= sid_reg;
                            res_ok_reg    <= 1'b1;
                            state_reg     <= S_DONE;
                        end
                        else
                        begin
                            sidx_reg  <= sidx_reg + FW'(1);
                            state_reg <= S_RAI_RD;
                        end
                    end
                    // Remove by ID.
                    S_RMI_RD:
                    begin
                        state_reg <= S_RMI_CHK;
                    end
                    S_RMI_CHK:
                    begin
                        if (slot_rdata == '0)
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            idx_reg   <= CW'(rsid_x);
                            state_reg <= S_REMOVE;
                        end
                    end
                    // Remove by handle: first match from ID 1.
                    S_RMH_RD:
                    begin
                        state_reg <= (idx_reg < siu_reg) ? S_RMH_CHK : S_DONE;
                    end
                    S_RMH_CHK:
                    begin
                        if (slot_rdata == h_reg)
                            state_reg <= S_REMOVE;
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_RMH_RD;
                        end
                    end
                    S_REMOVE:
                    begin
                        if (push_ok_w)
                            fc_reg <= fc_reg + FW'(1);
                        res_ok_reg     <= 1'b1;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_DONE;
                    end
                    S_GET_RD:
                    begin
                        state_reg <= S_GET_CHK;
                    end
                    S_GET_CHK:
                    begin
                        res_found_reg <= found_x[FOUND_W-1:0];
                        state_reg     <= S_DONE;
                    end
                    // Load the output register once it is free.
                    S_DONE:
                    begin
                        if (!out_valid_reg || rsp.ready)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_given_reg  <= res_given_reg;
                            out_found_reg  <= res_found_reg;
                            out_ok_reg     <= res_ok_reg;
                            out_status_reg <= res_status_reg;
                            clr_req_reg    <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_INIT;
                    end
                endcase
            end
        end
    end

    // The free count never passes the stack depth.
    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg <= FW'(FREE_DEPTH))
        else $error("free count beyond stack depth");

    // The in-use size stays within 1..limit outside re-initialization.
    a_siu_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_INIT) |-> (siu_reg != '0 && siu_reg <= lim_w))
        else $error("in-use size out of range");

    // An accepted request keeps req.ready low in the cycle after it.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && !cfg_we) |=> !req.ready)
        else $error("second request accepted back to back");

    // A response is loaded only when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(out_given_reg)
                                           && $stable(out_status_reg)))
        else $error("pending response overwritten");

endmodule

`default_nettype wire
